/* design/assert_macros.svh */
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

/* design/hpt_pkg.sv */
// ---------------------------------------------------------------------------
// hpt_pkg
// shared constants and types of the point transform
// ---------------------------------------------------------------------------
package hpt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int NUM_REGS    = 8;
  localparam int REG_IDX_W   = 3;
  localparam int PROD_W      = 2 * COORD_WIDTH;
  localparam int SUM_W       = PROD_W + 2;
  localparam int NUM_W       = SUM_W + FRAC_BITS;
  localparam int QFIFO_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam logic [REG_IDX_W-1:0] REG_R0_C01 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_R3_C23 = 3'd7;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  // item passed from the front part to the divide back part
  typedef struct packed {
    logic  w_zero;
    sum_t  nx;
    sum_t  ny;
    sum_t  nz;
    sum_t  w;
    coord_t px;
    coord_t py;
    coord_t pz;
  } front_item_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   w_zero;
    logic   saturated;
  } result_t;

endpackage

/* design/hpt_front.sv */
// ---------------------------------------------------------------------------
// hpt_front
// matrix multiply pipeline: products, sums, zero-w test
// ---------------------------------------------------------------------------
module hpt_front
  import hpt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_idx,
  input  logic [63:0]          cfg_data,
  input  logic                 in_valid,
  input  coord_t               in_x,
  input  coord_t               in_y,
  input  coord_t               in_z,
  input  logic                 adv,
  output logic                 out_valid,
  output front_item_t          out_item
);

  logic [63:0] mreg [NUM_REGS];
  logic signed [PROD_W-1:0] prod [4][3];
  coord_t mc [4];
  coord_t px1, py1, pz1;
  logic v1;
  sum_t s [4];

  function automatic coord_t ent(input logic [63:0] r, input logic hi);
    ent = hi ? coord_t'(r[63:32]) : coord_t'(r[31:0]);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      mreg[0] <= 64'd281474976710656;
      mreg[1] <= 64'd0;
      mreg[2] <= 64'd65536;
      mreg[3] <= 64'd0;
      mreg[4] <= 64'd0;
      mreg[5] <= 64'd281474976710656;
      mreg[6] <= 64'd0;
      mreg[7] <= 64'd65536;
    end else if (cfg_we) begin
      mreg[cfg_idx] <= cfg_data;
    end
  end

  // stage 1: twelve products, row 3 constants held
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        prod[c][0] <= PROD_W'(in_x * ent(mreg[c/2], c % 2 == 0));
        prod[c][1] <= PROD_W'(in_y * ent(mreg[2 + c/2], c % 2 == 0));
        prod[c][2] <= PROD_W'(in_z * ent(mreg[4 + c/2], c % 2 == 0));
        mc[c] <= ent(mreg[6 + c/2], c % 2 == 0);
      end
      px1 <= in_x;
      py1 <= in_y;
      pz1 <= in_z;
    end
  end

  // stage 2: column sums
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      s[c] = SUM_W'(prod[c][0]) + SUM_W'(prod[c][1]) + SUM_W'(prod[c][2])
           + (SUM_W'(mc[c]) <<< FRAC_BITS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.nx <= s[0];
      out_item.ny <= s[1];
      out_item.nz <= s[2];
      out_item.w  <= s[3];
      out_item.w_zero <= (s[3] == '0);
      out_item.px <= px1;
      out_item.py <= py1;
      out_item.pz <= pz1;
    end
  end

endmodule

/* design/hpt_queue.sv */
// ---------------------------------------------------------------------------
// hpt_queue
// small queue of front items between the multiply and divide parts
// ---------------------------------------------------------------------------
module hpt_queue
  import hpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr,
  input  front_item_t wr_item,
  input  logic        rd,
  output logic        nonempty,
  output logic [QPTR_W:0] count,
  output front_item_t rd_item
);
  `include "assert_macros.svh"

  front_item_t mem [QFIFO_DEPTH];
  logic [QPTR_W-1:0] wp, rp;

  assign nonempty = (count != '0);
  assign rd_item  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + 1'b1;
      if (rd) rp <= rp + 1'b1;
      count <= count + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
    end
  end

  `ASSERT_NEVER(a_q_over, clk, rst, wr && !rd && count == (QPTR_W+1)'(QFIFO_DEPTH), "queue overflow")
  `ASSERT_NEVER(a_q_under, clk, rst, rd && count == '0, "queue underflow")

endmodule

/* design/hpt_divide.sv */
// ---------------------------------------------------------------------------
// hpt_divide
// pipelined signed divide of three numerators by w, one quotient bit a stage
// ---------------------------------------------------------------------------
module hpt_divide
  import hpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  front_item_t in_item,
  output logic        out_valid,
  output result_t     out_res
);

  // quotient bits needed: COORD_WIDTH plus one guard bit; with the hi check this catches every overflow
  localparam int QB = COORD_WIDTH + 1;
  localparam int AW = NUM_W;          // magnitude width of shifted numerator
  localparam int DW = SUM_W;

  typedef struct packed {
    logic               v;
    logic               wz;
    logic [2:0]         neg;
    logic [2:0]         hi;           // quotient already known too large
    logic [DW-1:0]      d;
    logic [2:0][AW-1:0] n;
    logic [2:0][DW:0]   r;
    logic [2:0][QB-1:0] q;
    coord_t             px, py, pz;
  } dstage_t;

  dstage_t st [QB+1];

  // stage 0: magnitudes and high-bit overflow check
  always_ff @(posedge clk) begin
    logic [DW-1:0] aw;
    logic [DW-1:0] an;
    sum_t num;
    if (rst) begin
      st[0].v <= 1'b0;
    end else if (adv) begin
      st[0].v <= in_valid;
    end
    if (adv) begin
      aw = in_item.w[DW-1] ? DW'(-in_item.w) : DW'(in_item.w);
      st[0].d  <= aw;
      st[0].wz <= in_item.w_zero;
      st[0].px <= in_item.px;
      st[0].py <= in_item.py;
      st[0].pz <= in_item.pz;
      for (int k = 0; k < 3; k++) begin
        num = (k == 0) ? in_item.nx : (k == 1) ? in_item.ny : in_item.nz;
        an = num[DW-1] ? DW'(-num) : DW'(num);
        st[0].neg[k] <= num[DW-1] ^ in_item.w[DW-1];
        // bits of the quotient above QB: any nonzero means overflow
        st[0].n[k] <= AW'({an, FRAC_BITS'(0)});
        st[0].hi[k] <= ((AW'({an, FRAC_BITS'(0)}) >> QB) >= AW'(aw)) && (aw != '0);
        st[0].r[k] <= '0;
        st[0].q[k] <= '0;
      end
    end
  end

  // restoring division stages: one quotient bit each
  for (genvar g = 0; g < QB; g++) begin : g_div
    always_ff @(posedge clk) begin
      logic [DW:0] t;
      if (rst) begin
        st[g+1].v <= 1'b0;
      end else if (adv) begin
        st[g+1].v <= st[g].v;
      end
      if (adv) begin
        st[g+1].d   <= st[g].d;
        st[g+1].wz  <= st[g].wz;
        st[g+1].neg <= st[g].neg;
        st[g+1].hi  <= st[g].hi;
        st[g+1].px  <= st[g].px;
        st[g+1].py  <= st[g].py;
        st[g+1].pz  <= st[g].pz;
        for (int k = 0; k < 3; k++) begin
          st[g+1].n[k] <= st[g].n[k];
          t = (g == 0) ? (DW+1)'(st[g].n[k] >> QB) : st[g].r[k];
          t = {t[DW-1:0], st[g].n[k][QB-1-g]};
          if (t >= {1'b0, st[g].d}) begin
            st[g+1].r[k] <= t - {1'b0, st[g].d};
            st[g+1].q[k] <= st[g].q[k] | (QB'(1) << (QB-1-g));
          end else begin
            st[g+1].r[k] <= t;
            st[g+1].q[k] <= st[g].q[k];
          end
        end
      end
    end
  end

  // final: sign, saturation, zero-w pass through
  always_ff @(posedge clk) begin
    logic sat;
    coord_t c [3];
    logic [QB-1:0] lim;
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= st[QB].v;
    end
    if (adv) begin
      lim = QB'(1) << (COORD_WIDTH-1);
      sat = 1'b0;
      for (int k = 0; k < 3; k++) begin
        if (st[QB].neg[k]) begin
          if (st[QB].hi[k] || st[QB].q[k] > lim) begin
            sat = 1'b1;
            c[k] = coord_t'(lim);
          end else begin
            c[k] = coord_t'(-st[QB].q[k]);
          end
        end else begin
          if (st[QB].hi[k] || st[QB].q[k] > lim - 1'b1) begin
            sat = 1'b1;
            c[k] = coord_t'(lim - 1'b1);
          end else begin
            c[k] = coord_t'(st[QB].q[k]);
          end
        end
      end
      if (st[QB].wz) begin
        out_res.x <= st[QB].px;
        out_res.y <= st[QB].py;
        out_res.z <= st[QB].pz;
        out_res.w_zero <= 1'b1;
        out_res.saturated <= 1'b0;
      end else begin
        out_res.x <= c[0];
        out_res.y <= c[1];
        out_res.z <= c[2];
        out_res.w_zero <= 1'b0;
        out_res.saturated <= sat;
      end
    end
  end

endmodule

/* design/homogeneous_point_transform_unit.sv */
// ---------------------------------------------------------------------------
// homogeneous_point_transform_unit
// 4x4 point transform with perspective divide, Q16.16
// ---------------------------------------------------------------------------
//  port group      direction  handshake
//  in_x/y/z        in         push / full
//  out_x/y/z, flags out       empty / pop
//  cfg             in         cfg_we, no wait
//
// one point per cycle sustained while full stays low; from push to the
// earliest pop: 2 multiply stages, one middle queue stage, 35 divide
// stages (setup, 33 quotient bits, saturate), one output queue stage.
// the divide pipeline freezes while the output queue is full; the front
// stalls only when the middle queue cannot take two more items.
// synchronous reset loads the identity matrix and empties all queues.
module homogeneous_point_transform_unit
  import hpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  coord_t      in_x,
  input  coord_t      in_y,
  input  coord_t      in_z,
  output logic        empty,
  input  logic        pop,
  output coord_t      out_x,
  output coord_t      out_y,
  output coord_t      out_z,
  output logic        w_zero,
  output logic        saturated
);
  `include "assert_macros.svh"

  localparam int OQ_DEPTH = 16;
  localparam int OQ_W = 4;

  logic f_valid, f_adv, q_ne, q_rd, d_adv, d_valid;
  logic [QPTR_W:0] q_count;
  front_item_t f_item, q_item;
  result_t d_res;
  result_t oq [OQ_DEPTH];
  logic [OQ_W-1:0] owp, orp;
  logic [OQ_W:0] ocount;
  logic push_ok;

  // front stalls as a whole when the middle queue cannot take two more
  assign f_adv   = (q_count <= (QPTR_W+1)'(QFIFO_DEPTH - 2));
  assign full    = !f_adv;
  assign push_ok = push && !full;

  hpt_front u_front (
    .clk, .rst, .cfg_we(cfg_we && cfg_idx < 8'(NUM_REGS)),
    .cfg_idx(cfg_idx[REG_IDX_W-1:0]), .cfg_data,
    .in_valid(push_ok), .in_x, .in_y, .in_z, .adv(f_adv),
    .out_valid(f_valid), .out_item(f_item)
  );

  // divide advances while the output queue has room for one more item
  assign d_adv = (ocount < (OQ_W+1)'(OQ_DEPTH));
  assign q_rd  = d_adv && q_ne;

  hpt_queue u_queue (
    .clk, .rst, .wr(f_valid && f_adv), .wr_item(f_item), .rd(q_rd),
    .nonempty(q_ne), .count(q_count), .rd_item(q_item)
  );

  hpt_divide u_div (
    .clk, .rst, .adv(d_adv), .in_valid(q_rd), .in_item(q_item),
    .out_valid(d_valid), .out_res(d_res)
  );

  logic o_wr, o_rd;
  assign o_wr  = d_valid && d_adv;
  assign empty = (ocount == '0);
  assign o_rd  = pop && !empty;

  always_ff @(posedge clk) begin
    if (o_wr) oq[owp] <= d_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp <= '0;
      orp <= '0;
      ocount <= '0;
    end else begin
      if (o_wr) owp <= owp + 1'b1;
      if (o_rd) orp <= orp + 1'b1;
      ocount <= ocount + (OQ_W+1)'(o_wr) - (OQ_W+1)'(o_rd);
    end
  end

  assign out_x = oq[orp].x;
  assign out_y = oq[orp].y;
  assign out_z = oq[orp].z;
  assign w_zero = oq[orp].w_zero;
  assign saturated = oq[orp].saturated;

  `ASSERT_NEVER(a_oq_over, clk, rst, o_wr && !o_rd && ocount == (OQ_W+1)'(OQ_DEPTH), "oq overflow")
  `ASSERT_IMPL(a_flags, clk, rst, !empty, !(w_zero && saturated), "w_zero with saturated")

endmodule

/* tb/tb_top.sv */
// ---------------------------------------------------------------------------
// tb_top
// drives points into the homogeneous point transform and compares every
// transformed point against an exact in-bench model of the 4x4 transform and
// perspective divide, over several matrix settings with random idling
// ---------------------------------------------------------------------------
module tb_top;
  import hpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 60;
  localparam int STALL_LIMIT = 20000;
  localparam int NUM_RAND    = 1350;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        wz;
    logic        sat;
  } point_res_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    bit          known;
    point_res_t  res;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [7:0]  cfg_idx;
  logic [63:0] cfg_data;
  logic        push;
  logic        full;
  coord_t      in_x, in_y, in_z;
  logic        empty;
  logic        pop;
  coord_t      out_x, out_y, out_z;
  logic        w_zero, saturated;

  logic [63:0] matrix_regs [NUM_REGS];
  point_res_t  pending_points [$];
  int          fail_count;
  int          idle_cycles;
  bit          hold_off;
  bit          stim_done;

  homogeneous_point_transform_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic signed [127:0] mat_entry(int k);
    logic [63:0] r;
    r = matrix_regs[k >> 1];
    return (k & 1) ? 128'(signed'(r[31:0])) : 128'(signed'(r[63:32]));
  endfunction

  function automatic logic signed [127:0] column_sum(int c, logic signed [127:0] x,
      logic signed [127:0] y, logic signed [127:0] z);
    return x * mat_entry(c) + y * mat_entry(4 + c) + z * mat_entry(8 + c)
         + (mat_entry(12 + c) <<< FRAC_BITS);
  endfunction

  function automatic logic [31:0] persp_div(logic signed [127:0] num,
      logic signed [127:0] w, inout bit sat);
    logic signed [127:0] q;
    q = (num <<< FRAC_BITS) / w;  // truncates toward zero
    if (q > 128'sd2147483647) begin
      sat = 1'b1;
      return 32'h7fffffff;
    end
    if (q < -128'sd2147483648) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return q[31:0];
  endfunction

  function automatic point_res_t transform_point(logic [31:0] xi, logic [31:0] yi,
      logic [31:0] zi);
    logic signed [127:0] x, y, z, w;
    point_res_t r;
    bit sat;
    x = 128'(signed'(xi));
    y = 128'(signed'(yi));
    z = 128'(signed'(zi));
    w = column_sum(3, x, y, z);
    sat = 1'b0;
    if (w == 0) begin
      r = '{xi, yi, zi, 1'b1, 1'b0};
    end else begin
      r.x = persp_div(column_sum(0, x, y, z), w, sat);
      r.y = persp_div(column_sum(1, x, y, z), w, sat);
      r.z = persp_div(column_sum(2, x, y, z), w, sat);
      r.wz = 1'b0;
      r.sat = sat;
    end
    return r;
  endfunction

  // one write, then cfg_we low again so back to back writes never collide
  task automatic write_reg(int idx, logic [63:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= 8'(idx);
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx < NUM_REGS) matrix_regs[idx] = val;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
      bit known, point_res_t res);
    push <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    @(posedge clk);
    while (full) @(posedge clk);
    pending_points.push_back(known ? res : transform_point(x, y, z));
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_entry();
    case ($urandom_range(0, 4))
      0: return 32'h00010000;
      1: return 32'h0;
      2: return 32'($signed($urandom_range(0, 4 << 16)) - (2 << 16));
      default: return $urandom;
    endcase
  endfunction

  task automatic load_random_matrix(int mode);
    logic [63:0] v;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (mode)
        0: v = '1;
        1: v = '0;
        2: v = 64'h7fffffff_80000000;
        default: v = {rand_entry(), rand_entry()};
      endcase
      write_reg(i, v);
    end
  endtask

  // result side: random stall pattern plus one long hold-off
  initial begin
    pop <= 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) pop <= 1'b0;
      else pop <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 7) == 0);
    end
  end

  always @(posedge clk) begin
    point_res_t exp_r;
    if (!rst && pop && !empty) begin
      if (pending_points.size() == 0) begin
        $error("result with no item outstanding");
        fail_count++;
      end else begin
        exp_r = pending_points.pop_front();
        if (out_x !== exp_r.x) begin
          $error("out_x expected %h actual %h", exp_r.x, out_x); fail_count++;
        end
        if (out_y !== exp_r.y) begin
          $error("out_y expected %h actual %h", exp_r.y, out_y); fail_count++;
        end
        if (out_z !== exp_r.z) begin
          $error("out_z expected %h actual %h", exp_r.z, out_z); fail_count++;
        end
        if (w_zero !== exp_r.wz) begin
          $error("w_zero expected %b actual %b", exp_r.wz, w_zero); fail_count++;
        end
        if (saturated !== exp_r.sat) begin
          $error("saturated expected %b actual %b", exp_r.sat, saturated); fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || cfg_we) idle_cycles <= 0;
    else if (pending_points.size() != 0 || !stim_done) idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    int burst;
    int n_rand;
    bit pressed;
    rst = 1'b1; cfg_we = 1'b0; cfg_idx = '0; cfg_data = '0;
    push = 1'b0; in_x = '0; in_y = '0; in_z = '0;
    fail_count = 0; idle_cycles = 0; hold_off = 1'b0; stim_done = 1'b0;
    pressed = 1'b0;
    matrix_regs = '{64'h00010000_00000000, 64'h0, 64'h00000000_00010000, 64'h0,
                    64'h0, 64'h00010000_00000000, 64'h0, 64'h00000000_00010000};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // identity after reset: points come back unchanged
    dir_rows.push_back('{32'h0, 32'h0, 32'h0, 1, '{32'h0, 32'h0, 32'h0, 0, 0}});
    dir_rows.push_back('{32'h7fffffff, 32'h80000000, 32'h00010000, 1,
                         '{32'h7fffffff, 32'h80000000, 32'h00010000, 0, 0}});
    dir_rows.push_back('{32'h80000000, 32'h7fffffff, 32'hffffffff, 1,
                         '{32'h80000000, 32'h7fffffff, 32'hffffffff, 0, 0}});
    dir_rows.push_back('{32'h12345678, 32'hfedcba98, 32'h00000001, 0, '0});
    foreach (dir_rows[i])
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].known,
                 dir_rows[i].res);
    push <= 1'b0;
    wait_drained();

    // w forced to zero: passthrough with the flag
    write_reg(7, 64'h0);
    write_reg(8, 64'hdeadbeef_deadbeef);  // out of range index, ignored
    dir_rows.delete();
    dir_rows.push_back('{32'h00030000, 32'hfffd0000, 32'h7fffffff, 1,
                         '{32'h00030000, 32'hfffd0000, 32'h7fffffff, 1, 0}});
    dir_rows.push_back('{32'h80000000, 32'h0, 32'h1, 1,
                         '{32'h80000000, 32'h0, 32'h1, 1, 0}});
    dir_rows.push_back('{32'h7fffffff, 32'h1, 32'h0, 0, '0});
    dir_rows.push_back('{32'h80000000, 32'h1, 32'h0, 0, '0});
    foreach (dir_rows[i])
      send_point(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z, dir_rows[i].known,
                 dir_rows[i].res);
    push <= 1'b0;
    wait_drained();
    // w made to follow x, x' huge: saturation at the positive limit for both signs of x, then a zero w
    write_reg(7, 64'h00000000_00000001);
    write_reg(1, 64'h00000000_00000001);
    send_point(32'h7fffffff, 32'h0, 32'h0, 0, '0);
    send_point(32'h80000000, 32'h0, 32'h0, 0, '0);
    send_point(32'hffff0000, 32'h7fffffff, 32'h0, 0, '0);
    push <= 1'b0;
    wait_drained();

    // random phases over several matrix settings
    n_rand = 0;
    for (int phase = 0; phase < 9; phase++) begin
      load_random_matrix(phase < 3 ? phase : 3);
      while (n_rand < (phase + 1) * NUM_RAND / 9) begin
        burst = $urandom_range(1, 40);
        if (phase == 4 && !pressed) begin
          pressed = 1'b1;
          fork
            begin
              hold_off = 1'b1;
              repeat (300) @(posedge clk);
              hold_off = 1'b0;
            end
          join_none
          burst = 80;
        end
        repeat (burst) begin
          send_point(rand_coord(), rand_coord(), rand_coord(), 0, '0);
          n_rand++;
        end
        if ($urandom_range(0, 2) != 0) begin
          push <= 1'b0;
          repeat ($urandom_range(1, 12)) @(posedge clk);
        end
      end
      push <= 1'b0;
      wait_drained();
    end
    stim_done = 1'b1;

    if (fail_count == 0 && pending_points.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
